// File: rtl/core/fld_pkg.sv
`default_nettype none

package fld_pkg;

   // Frame store geometry
   localparam int MAX_WIDTH   = 128;
   localparam int MAX_HEIGHT  = 128;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   // Field widths
   localparam int COORD_W     = 16;
   localparam int COLOR_W     = 24;
   localparam int DIM_W       = 8;
   localparam int DELTA_W     = COORD_W + 1;
   localparam int ERR_W       = COORD_W + 4;
   localparam int LIN_W       = COORD_W + DIM_W;
   localparam int ACTION_W    = 2;
   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 32;

   // Command queue
   localparam int QUEUE_DEPTH = 2;

   // Configuration registers
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] REG_DISPLAY_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_DISPLAY_HEIGHT = CSR_IDX_W'(1);
   localparam logic [DIM_W-1:0]     WIDTH_RESET        = DIM_W'(128);
   localparam logic [DIM_W-1:0]     HEIGHT_RESET       = DIM_W'(128);

   typedef enum logic [ACTION_W-1:0] {
      ACT_PLOT  = 2'd0,
      ACT_LINE  = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } geom_type;

   typedef struct packed {
      action_type          action;
      logic                visible;
      logic [STORE_AW-1:0] addr;
      logic [COORD_W-1:0]  x0;
      logic [COORD_W-1:0]  y0;
      logic [COORD_W-1:0]  x1;
      logic [COORD_W-1:0]  y1;
      logic [DELTA_W-1:0]  dx;
      logic [DELTA_W-1:0]  dy;
      logic                x_neg;
      logic                y_neg;
      logic [COLOR_W-1:0]  color;
   } cmd_type;

   typedef struct packed {
      logic                we;
      logic [STORE_AW-1:0] addr;
      logic [COLOR_W-1:0]  wdata;
   } ram_req_type;

   function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
                                                input int unsigned lim);
      if (32'(v) > lim) return DIM_W'(lim);
      return v;
   endfunction

   function automatic logic on_screen(input logic [COORD_W-1:0] x,
                                      input logic [COORD_W-1:0] y,
                                      input geom_type g);
      return !x[COORD_W-1] && !y[COORD_W-1] &&
             (x < COORD_W'(g.width)) && (y < COORD_W'(g.height));
   endfunction

   // Only meaningful for on-screen points, where y*W + x stays below the depth
   function automatic logic [STORE_AW-1:0] addr_of(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y,
                                                   input logic [DIM_W-1:0]   w);
      logic [LIN_W-1:0] lin;
      lin = LIN_W'(y) * LIN_W'(w) + LIN_W'(x);
      return lin[STORE_AW-1:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/framebuffer_line_drawer.sv
`default_nettype none

// Frame store with a small drawing engine (24-bit color, up to 128 x 128).
// Request channel (req_): one command per transaction. tuser carries the
// action (plot, line, clear, read); tdata carries the coordinates and color.
// Response channel (rsp_): exactly one transaction per command, in order.
// Configuration channel (csr_): register 0 is display width, register 1 is
// display height; other indexes are dropped. Always ready; write only while
// no command is in flight.
// Reset: the store is wiped to zero by a pass over every word, one word per
// cycle, during which req_tready stays low. Registers return to 128 x 128.
// A line walks its points one at a time and a clear scans the active area
// row by row (the scan still walks a zero-sized side once). Throughput is
// set by the single frame store port: the back end writes one pixel per
// cycle and runs one command at a time.
// A two-entry command queue sits between the classifying front end and the
// drawing back end, so new requests are taken while the back end works or
// while a response waits. When the receiver stalls, the response is held in
// its output register and the back end stops popping the queue.

module framebuffer_line_drawer import fld_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // req_tuser:  [1:0] action
   // req_tdata:  [15:0] x_start, [31:16] y_start, [47:32] x_end, [63:48] y_end,
   //             [87:64] color
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [ACTION_W-1:0]    req_tuser,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // rsp_tdata:  [23:0] pixel_color, [24] inside_res, [31:25] zero
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // Configuration writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [DIM_W-1:0]       csr_data
);

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   geom_type         geom;
   logic             init_busy;
   logic             push_valid;
   logic             push_ready;
   cmd_type          push_cmd;
   logic             pop_valid;
   logic             pop_ready;
   cmd_type          pop_cmd;
   ram_req_type      ram_req;
   logic [COLOR_W-1:0] ram_rdata;

   // Register file: take every write transaction, drop unknown indexes
   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_DISPLAY_WIDTH:  width_in  = csr_data;
            REG_DISPLAY_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Clamp oversized geometry to the store size
   assign geom.width  = sat_dim(width_ff, MAX_WIDTH);
   assign geom.height = sat_dim(height_ff, MAX_HEIGHT);

   fld_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .geom       (geom),
      .init_busy  (init_busy),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   fld_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   fld_back u_back (
      .clock      (clock),
      .reset      (reset),
      .geom       (geom),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd),
      .ram_req    (ram_req),
      .ram_rdata  (ram_rdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .init_busy  (init_busy)
   );

   // Frame store: one port, registered read
   fld_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_req.we),
      .addr  (ram_req.addr),
      .wdata (ram_req.wdata),
      .rdata (ram_rdata)
   );

endmodule

`default_nettype wire

// File: rtl/core/fld_ram.sv
`default_nettype none

module fld_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16384,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end

endmodule

`default_nettype wire

// File: rtl/core/fld_front.sv
`default_nettype none

module fld_front import fld_pkg::*; (
   // Request channel
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [ACTION_W-1:0]    req_tuser,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // Active geometry and init pass status
   input  wire geom_type               geom,
   input  wire logic                   init_busy,
   // Queue push side
   output logic                        push_valid,
   input  wire logic                   push_ready,
   output cmd_type                     push_cmd
);

   logic [COORD_W-1:0] xs;
   logic [COORD_W-1:0] ys;
   logic [COORD_W-1:0] xe;
   logic [COORD_W-1:0] ye;
   logic [DELTA_W-1:0] diff_x;
   logic [DELTA_W-1:0] diff_y;

   assign xs = req_tdata[15:0];
   assign ys = req_tdata[31:16];
   assign xe = req_tdata[47:32];
   assign ye = req_tdata[63:48];

   // Sign-extended differences, then magnitudes for the error walk
   assign diff_x = {xe[COORD_W-1], xe} - {xs[COORD_W-1], xs};
   assign diff_y = {ye[COORD_W-1], ye} - {ys[COORD_W-1], ys};

   always_comb begin
      push_cmd.action  = action_type'(req_tuser);
      push_cmd.visible = on_screen(xs, ys, geom);
      push_cmd.addr    = addr_of(xs, ys, geom.width);
      push_cmd.x0      = xs;
      push_cmd.y0      = ys;
      push_cmd.x1      = xe;
      push_cmd.y1      = ye;
      push_cmd.dx      = diff_x[DELTA_W-1] ? (DELTA_W'(0) - diff_x) : diff_x;
      push_cmd.dy      = diff_y[DELTA_W-1] ? (DELTA_W'(0) - diff_y) : diff_y;
      push_cmd.x_neg   = !($signed(xs) < $signed(xe));
      push_cmd.y_neg   = !($signed(ys) < $signed(ye));
      push_cmd.color   = req_tdata[87:64];
   end

   // Hold off requests while the store is being wiped after reset
   assign push_valid = req_tvalid && !init_busy;
   assign req_tready = push_ready && !init_busy;

endmodule

`default_nettype wire

// File: rtl/core/fld_cmd_queue.sv
`default_nettype none

module fld_cmd_queue import fld_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   output logic         push_ready,
   input  wire cmd_type push_cmd,
   output logic         pop_valid,
   input  wire logic    pop_ready,
   output cmd_type      pop_cmd
);

   localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [QAW-1:0] PTR_LAST = QAW'(QUEUE_DEPTH - 1);
   localparam logic [QCW-1:0] CNT_FULL = QCW'(QUEUE_DEPTH);

   cmd_type        slots_ff [QUEUE_DEPTH];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0] count_ff, count_in;
   logic           do_push;
   logic           do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != QCW'(0));
   assign pop_cmd    = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? QAW'(0) : wr_ptr_ff + QAW'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? QAW'(0) : rd_ptr_ff + QAW'(1);
      if (do_push && !do_pop)      count_in = count_ff + QCW'(1);
      else if (do_pop && !do_push) count_in = count_ff - QCW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slots_ff[wr_ptr_ff] <= push_cmd;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("command queue count out of range");
`endif

endmodule

`default_nettype wire

// File: rtl/core/fld_back.sv
`default_nettype none

module fld_back import fld_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire geom_type               geom,
   // Queue pop side
   input  wire logic                   pop_valid,
   output logic                        pop_ready,
   input  wire cmd_type                pop_cmd,
   // Frame store port
   output ram_req_type                 ram_req,
   input  wire logic [COLOR_W-1:0]     ram_rdata,
   // Response channel
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                        init_busy
);

   typedef enum logic [4:0] {
      ST_INIT  = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_LINE  = 5'b00100,
      ST_CLEAR = 5'b01000,
      ST_READ  = 5'b10000
   } state_type;

   localparam logic [STORE_AW-1:0] INIT_LAST = STORE_AW'(STORE_DEPTH - 1);

   state_type           state_ff, state_in;
   logic [STORE_AW-1:0] init_addr_ff, init_addr_in;
   logic [COORD_W-1:0]  cur_x_ff, cur_x_in;
   logic [COORD_W-1:0]  cur_y_ff, cur_y_in;
   logic [COORD_W-1:0]  end_x_ff, end_x_in;
   logic [COORD_W-1:0]  end_y_ff, end_y_in;
   logic [DELTA_W-1:0]  dx_ff, dx_in;
   logic [DELTA_W-1:0]  dy_ff, dy_in;
   logic                x_neg_ff, x_neg_in;
   logic                y_neg_ff, y_neg_in;
   logic [ERR_W-1:0]    err_ff, err_in;
   logic [COLOR_W-1:0]  color_ff, color_in;
   logic                inside_ff, inside_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0]  rsp_color_ff, rsp_color_in;
   logic                rsp_inside_ff, rsp_inside_in;

   logic                slot_free;
   logic                pop;
   logic                cur_on;
   logic [STORE_AW-1:0] cur_addr;
   logic                at_end;
   logic signed [ERR_W:0] e2;
   logic signed [ERR_W:0] neg_dy;
   logic signed [ERR_W:0] pos_dx;
   logic                step_x;
   logic                step_y;
   logic [ERR_W-1:0]    err_next;
   logic                last_x;
   logic                last_y;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign pop_ready = (state_ff == ST_IDLE) && slot_free;
   assign pop       = pop_valid && pop_ready;
   assign init_busy = (state_ff == ST_INIT);

   // Current walk point, shared by line and clear
   assign cur_on   = on_screen(cur_x_ff, cur_y_ff, geom);
   assign cur_addr = addr_of(cur_x_ff, cur_y_ff, geom.width);

   // Bresenham error step
   assign at_end   = (cur_x_ff == end_x_ff) && (cur_y_ff == end_y_ff);
   assign e2       = $signed({err_ff, 1'b0});
   assign pos_dx   = $signed((ERR_W+1)'(dx_ff));
   assign neg_dy   = -$signed((ERR_W+1)'(dy_ff));
   assign step_x   = (e2 > neg_dy);
   assign step_y   = (e2 < pos_dx);
   assign err_next = err_ff - (step_x ? ERR_W'(dy_ff) : ERR_W'(0))
                            + (step_y ? ERR_W'(dx_ff) : ERR_W'(0));

   // Raster scan limits for clear
   assign last_x = (({1'b0, cur_x_ff} + (COORD_W+1)'(1)) >= (COORD_W+1)'(geom.width));
   assign last_y = (({1'b0, cur_y_ff} + (COORD_W+1)'(1)) >= (COORD_W+1)'(geom.height));

   always_comb begin
      state_in      = state_ff;
      init_addr_in  = init_addr_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      end_x_in      = end_x_ff;
      end_y_in      = end_y_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      x_neg_in      = x_neg_ff;
      y_neg_in      = y_neg_ff;
      err_in        = err_ff;
      color_in      = color_ff;
      inside_in     = inside_ff;
      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_inside_in = rsp_inside_ff;
      ram_req.we    = 1'b0;
      ram_req.addr  = cur_addr;
      ram_req.wdata = color_ff;

      unique case (state_ff)
         ST_INIT: begin
            ram_req.we    = 1'b1;
            ram_req.addr  = init_addr_ff;
            ram_req.wdata = '0;
            init_addr_in  = init_addr_ff + STORE_AW'(1);
            if (init_addr_ff == INIT_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (pop) begin
               color_in  = pop_cmd.color;
               inside_in = pop_cmd.visible;
               unique case (pop_cmd.action)
                  ACT_PLOT: begin
                     ram_req.we    = pop_cmd.visible;
                     ram_req.addr  = pop_cmd.addr;
                     ram_req.wdata = pop_cmd.color;
                     rsp_valid_in  = 1'b1;
                     rsp_color_in  = '0;
                     rsp_inside_in = pop_cmd.visible;
                  end
                  ACT_LINE: begin
                     cur_x_in = pop_cmd.x0;
                     cur_y_in = pop_cmd.y0;
                     end_x_in = pop_cmd.x1;
                     end_y_in = pop_cmd.y1;
                     dx_in    = pop_cmd.dx;
                     dy_in    = pop_cmd.dy;
                     x_neg_in = pop_cmd.x_neg;
                     y_neg_in = pop_cmd.y_neg;
                     err_in   = ERR_W'(pop_cmd.dx) - ERR_W'(pop_cmd.dy);
                     state_in = ST_LINE;
                  end
                  ACT_CLEAR: begin
                     cur_x_in = '0;
                     cur_y_in = '0;
                     state_in = ST_CLEAR;
                  end
                  ACT_READ: begin
                     ram_req.addr = pop_cmd.addr;
                     state_in     = ST_READ;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_LINE: begin
            ram_req.we = cur_on;
            if (at_end) begin
               rsp_valid_in  = 1'b1;
               rsp_color_in  = '0;
               rsp_inside_in = 1'b0;
               state_in      = ST_IDLE;
            end else begin
               err_in = err_next;
               if (step_x) cur_x_in = x_neg_ff ? cur_x_ff - COORD_W'(1) : cur_x_ff + COORD_W'(1);
               if (step_y) cur_y_in = y_neg_ff ? cur_y_ff - COORD_W'(1) : cur_y_ff + COORD_W'(1);
            end
         end
         ST_CLEAR: begin
            ram_req.we = cur_on;
            if (last_x && last_y) begin
               rsp_valid_in  = 1'b1;
               rsp_color_in  = '0;
               rsp_inside_in = 1'b0;
               state_in      = ST_IDLE;
            end else if (last_x) begin
               cur_x_in = '0;
               cur_y_in = cur_y_ff + COORD_W'(1);
            end else begin
               cur_x_in = cur_x_ff + COORD_W'(1);
            end
         end
         ST_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_color_in  = inside_ff ? ram_rdata : '0;
            rsp_inside_in = inside_ff;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_addr_ff <= init_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      end_x_ff      <= end_x_in;
      end_y_ff      <= end_y_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      x_neg_ff      <= x_neg_in;
      y_neg_ff      <= y_neg_in;
      err_ff        <= err_in;
      color_ff      <= color_in;
      inside_ff     <= inside_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_inside_ff <= rsp_inside_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W-COLOR_W-1)'(0), rsp_inside_ff, rsp_color_ff};

`ifndef SYNTHESIS
   a_read_responds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> rsp_valid_ff)
      else $error("read did not load a response");

   a_init_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT) |-> (!rsp_valid_ff && !pop_ready))
      else $error("activity during the store wipe");

   a_init_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT && init_addr_ff == INIT_LAST) |=> (state_ff == ST_IDLE))
      else $error("store wipe did not finish at the last address");
`endif

endmodule

`default_nettype wire

// File: dv/tb_framebuffer_line_drawer.sv
`timescale 1ns / 100ps

module tb_framebuffer_line_drawer import fld_pkg::*;;

   // Longest stretch without any transaction before the run is declared hung.
   localparam int IDLE_LIMIT      = 300_000;
   // Cycles to let pass once the last response is in, before a register write
   localparam int SETTLE_CYCLES   = 8;
   localparam int NUM_PHASES      = 10;
   localparam int ITEMS_PER_PHASE = 135;
   localparam int MAX_WAIT        = 11;
   // Indexes the block must drop
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_TOP   = '1;

   typedef struct {
      action_type                action;
      logic signed [COORD_W-1:0] xs;
      logic signed [COORD_W-1:0] ys;
      logic signed [COORD_W-1:0] xe;
      logic signed [COORD_W-1:0] ye;
      logic [COLOR_W-1:0]        color;
   } draw_cmd_type;

   typedef struct {
      logic [COLOR_W-1:0] color;
      logic               visible;
   } pixel_resp_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ACTION_W-1:0]    req_tuser  = '0;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [DIM_W-1:0]       csr_data   = '0;

   // Shadow copy of the frame store and the geometry registers
   logic [COLOR_W-1:0] shadow_frame [STORE_DEPTH];
   logic [DIM_W-1:0]   width_reg  = WIDTH_RESET;
   logic [DIM_W-1:0]   height_reg = HEIGHT_RESET;

   draw_cmd_type   pending_cmds [$];     // commands not yet offered to the block
   pixel_resp_type expected_pixels [$];  // responses owed by the block, oldest first
   draw_cmd_type   offered_cmd;
   pixel_resp_type oldest_pixel;
   int          req_wait       = 0;
   int          rsp_wait       = 0;
   int          mismatch_count = 0;
   int          idle_cycles    = 0;
   bit          steady_flow    = 1'b0;  // both sides run without gaps while set

   framebuffer_line_drawer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Register values above the store size saturate to it
   function automatic int active_width();
      return (int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
   endfunction

   function automatic int active_height();
      return (int'(height_reg) > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
   endfunction

   function automatic bit on_display(int x, int y);
      return x >= 0 && y >= 0 && x < active_width() && y < active_height();
   endfunction

   // Off-screen points are dropped; the row pitch is the current width
   function automatic void paint(int x, int y, logic [COLOR_W-1:0] c);
      if (on_display(x, y))
         shadow_frame[y * active_width() + x] = c;
   endfunction

   // Apply one accepted command to the shadow store and queue its response
   function automatic void render_command(draw_cmd_type c);
      pixel_resp_type r;
      int          x0, y0, x1, y1, dx, dy, sx, sy, err, e2;
      bit          done;
      r.color   = '0;
      r.visible = 1'b0;
      x0 = c.xs;
      y0 = c.ys;
      x1 = c.xe;
      y1 = c.ye;
      case (c.action)
         ACT_PLOT: begin
            r.visible = on_display(x0, y0);
            paint(x0, y0, c.color);
         end
         ACT_LINE: begin
            // Error walk over all octants; a start equal to the end plots one point
            dx   = (x1 > x0) ? x1 - x0 : x0 - x1;
            dy   = (y1 > y0) ? y1 - y0 : y0 - y1;
            sx   = (x0 < x1) ? 1 : -1;
            sy   = (y0 < y1) ? 1 : -1;
            err  = dx - dy;
            done = 1'b0;
            while (!done) begin
               paint(x0, y0, c.color);
               if (x0 == x1 && y0 == y1) begin
                  done = 1'b1;
               end else begin
                  e2 = 2 * err;
                  if (e2 > -dy) begin
                     err -= dy;
                     x0  += sx;
                  end
                  if (e2 < dx) begin
                     err += dx;
                     y0  += sy;
                  end
               end
            end
         end
         ACT_CLEAR: begin
            for (int row = 0; row < active_height(); row++)
               for (int col = 0; col < active_width(); col++)
                  paint(col, row, c.color);
         end
         ACT_READ: begin
            if (on_display(x0, y0)) begin
               r.visible = 1'b1;
               r.color   = shadow_frame[y0 * active_width() + x0];
            end
         end
      endcase
      expected_pixels.push_back(r);
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic void push_cmd(action_type a, int xs, int ys, int xe, int ye,
                                    int unsigned color);
      draw_cmd_type c;
      c.action = a;
      c.xs     = COORD_W'(xs);
      c.ys     = COORD_W'(ys);
      c.xe     = COORD_W'(xe);
      c.ye     = COORD_W'(ye);
      c.color  = COLOR_W'(color);
      pending_cmds.push_back(c);
   endfunction

   // Mostly on screen, with a few points just past each edge
   function automatic int near_coord(int span);
      return int'($urandom_range(0, span + 8)) - 4;
   endfunction

   // Now and then anywhere in the 16-bit range
   function automatic int any_coord(int span);
      if ($urandom_range(0, 15) == 0)
         return int'($urandom);
      return near_coord(span);
   endfunction

   // Hold until the queue is empty and every response is in, then settle
   task automatic drain();
      while (pending_cmds.size() != 0 || req_tvalid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write transaction; the shadow copy follows on acceptance
   task automatic write_reg(logic [CSR_IDX_W-1:0] index, logic [DIM_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == REG_DISPLAY_WIDTH)
         width_reg = value;
      else if (index == REG_DISPLAY_HEIGHT)
         height_reg = value;
   endtask

   // ---------------------------------------------------------------------
   // Request driver: offer queued commands, predict each one on acceptance
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_wait = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            render_command(offered_cmd);
            req_wait = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
         end
         // Advance only when the current transaction is gone or none is offered
         if (!req_tvalid || req_tready) begin
            if (req_wait != 0) begin
               req_wait--;
               req_tvalid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
               offered_cmd = pending_cmds.pop_front();
               req_tuser  <= offered_cmd.action;
               req_tdata  <= {offered_cmd.color, offered_cmd.ye, offered_cmd.xe,
                              offered_cmd.ys, offered_cmd.xs};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor: compare each transaction with the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected response, expected none actual %h",
                        $time, rsp_tdata);
               mismatch_count++;
            end else begin
               oldest_pixel = expected_pixels.pop_front();
               if (rsp_tdata[COLOR_W-1:0] !== oldest_pixel.color) begin
                  $display("%0t: pixel_color mismatch, expected %06h actual %06h",
                           $time, oldest_pixel.color, rsp_tdata[COLOR_W-1:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[COLOR_W] !== oldest_pixel.visible) begin
                  $display("%0t: inside_res mismatch, expected %0b actual %0b",
                           $time, oldest_pixel.visible, rsp_tdata[COLOR_W]);
                  mismatch_count++;
               end
            end
            rsp_wait = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
         end else if (rsp_wait != 0 && rsp_tvalid) begin
            // stall counts only while a response is actually waiting
            rsp_wait--;
         end
         rsp_tready <= (rsp_wait == 0);
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: drop the run if no transaction moves for too long
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("%0t: watchdog expired with %0d responses outstanding",
                  $time, expected_pixels.size());
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      int          pick;
      int          wspan, hspan;
      bit          long_line;
      logic [DIM_W-1:0] geom_w, geom_h;

      for (int i = 0; i < STORE_DEPTH; i++)
         shadow_frame[i] = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part at reset geometry (128 x 128)
      push_cmd(ACT_READ,  0, 0, 0, 0, 0);                 // wiped store reads zero
      push_cmd(ACT_PLOT,  0, 0, -1, -1, 24'hFFFFFF);
      push_cmd(ACT_PLOT,  127, 127, 0, 0, 24'h123456);    // far corner
      push_cmd(ACT_PLOT,  128, 0, 0, 0, 24'h00FF00);      // one past the right edge
      push_cmd(ACT_PLOT,  -1, 5, 0, 0, 24'h0000FF);       // one left of the screen
      push_cmd(ACT_PLOT,  -32768, 32767, 32767, -32768, 24'hABCDEF);
      push_cmd(ACT_READ,  0, 0, 0, 0, 0);
      push_cmd(ACT_READ,  127, 127, 0, 0, 24'hFFFFFF);
      push_cmd(ACT_READ,  32767, -32768, -32768, 32767, 0);
      push_cmd(ACT_READ,  0, 128, 0, 0, 0);               // one below the screen
      push_cmd(ACT_LINE,  5, 5, 5, 5, 24'h0000FF);        // single-point line
      push_cmd(ACT_READ,  5, 5, 0, 0, 0);
      push_cmd(ACT_LINE,  -10, 3, 140, 3, 24'h00FF00);    // clipped at both ends
      push_cmd(ACT_LINE,  20, 100, 17, 2, 24'hFF0000);    // steep, walking up
      push_cmd(ACT_LINE,  100, 10, 0, 60, 24'h808080);    // shallow, walking left
      push_cmd(ACT_READ,  18, 50, 0, 0, 0);
      push_cmd(ACT_LINE,  -32768, -32768, 32767, 32767, 24'h5A5A5A);
      push_cmd(ACT_READ,  64, 64, 0, 0, 0);
      push_cmd(ACT_CLEAR, 0, 0, 0, 0, 24'hA5A5A5);
      push_cmd(ACT_READ,  127, 0, 0, 0, 0);
      push_cmd(ACT_PLOT,  0, 127, 0, 0, 24'h000000);
      push_cmd(ACT_READ,  0, 127, 0, 0, 0);
      push_cmd(ACT_READ,  3, 3, 0, 0, 0);
      drain();

      // Random part, one geometry per phase; the store keeps its contents
      // across geometry changes and is read back through the new pitch
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0:       begin geom_w = 8'd16;  geom_h = 8'd12;  end
            1:       begin geom_w = 8'd1;   geom_h = 8'd1;   end
            2:       begin geom_w = 8'd0;   geom_h = 8'd7;   end  // nothing on screen
            3:       begin geom_w = 8'd200; geom_h = 8'd255; end  // saturates
            4:       begin geom_w = 8'd9;   geom_h = 8'd0;   end  // nothing on screen
            5:       begin geom_w = 8'd37;  geom_h = 8'd5;   end
            6:       begin geom_w = 8'd255; geom_h = 8'd1;   end
            7:       begin geom_w = 8'd64;  geom_h = 8'd64;  end
            8:       begin geom_w = 8'd3;   geom_h = 8'd100; end
            default: begin geom_w = 8'd128; geom_h = 8'd128; end
         endcase
         if (p == 4) begin
            // indexes past the last register must change nothing
            write_reg(REG_SPARE, 8'h55);
            write_reg(REG_TOP, 8'hFF);
         end
         write_reg(REG_DISPLAY_WIDTH, geom_w);
         write_reg(REG_DISPLAY_HEIGHT, geom_h);
         steady_flow = (p % 3 == 2);
         wspan = active_width();
         hspan = active_height();

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 34) begin
               push_cmd(ACT_PLOT, any_coord(wspan), any_coord(hspan),
                        $urandom, $urandom, $urandom);
            end else if (pick < 64) begin
               // rare lines span the full coordinate range and run long
               long_line = ($urandom_range(0, 63) == 0);
               push_cmd(ACT_LINE,
                        long_line ? int'($urandom) : near_coord(wspan),
                        long_line ? int'($urandom) : near_coord(hspan),
                        long_line ? int'($urandom) : near_coord(wspan),
                        long_line ? int'($urandom) : near_coord(hspan),
                        $urandom);
            end else if (pick < 67) begin
               push_cmd(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
               push_cmd(ACT_READ, any_coord(wspan), any_coord(hspan),
                        $urandom, $urandom, $urandom);
            end
         end
         drain();
      end

      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/fld_pkg.sv
rtl/core/fld_ram.sv
rtl/core/fld_front.sv
rtl/core/fld_cmd_queue.sv
rtl/core/fld_back.sv
rtl/core/framebuffer_line_drawer.sv
dv/tb_framebuffer_line_drawer.sv
